>>> src/arpc_pkg.sv
// ----------------------------------------------------------------------------
// arpc_pkg: shared types and constants for the ARP cache resolver
// Slot state codes, result actions, request types, register indexes and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package arpc_pkg;

  typedef enum logic [1:0] {
    SLOT_UNUSED   = 2'd0,
    SLOT_PEND_NOMAC = 2'd1,
    SLOT_PEND_MAC = 2'd2,
    SLOT_RESOLVED = 2'd3
  } slot_st_t;

  typedef enum logic [1:0] {
    ACT_FWD   = 2'd0,
    ACT_DROP  = 2'd1,
    ACT_REQ   = 2'd2,
    ACT_REPLY = 2'd3
  } action_t;

  localparam logic [1:0] REQ_SEND  = 2'd0;
  localparam logic [1:0] REQ_FRAME = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;
  localparam logic [1:0] REQ_NONE  = 2'd3;

  localparam logic [1:0] CFG_LOCAL_IP      = 2'd0;
  localparam logic [1:0] CFG_PENDING_LIMIT = 2'd1;
  localparam logic [1:0] CFG_REFRESH_LIMIT = 2'd2;

  localparam logic [31:0] LOCAL_IP_RST      = 32'd0;
  localparam logic [15:0] PENDING_LIMIT_RST = 16'd5;
  localparam logic [15:0] REFRESH_LIMIT_RST = 16'd600;

  localparam logic [13:0] MIN_FRAME   = 14'd42;
  localparam logic [47:0] GOOD_HEADER = 48'h0001_0800_0604;
  localparam logic [15:0] OP_REQUEST  = 16'd1;
  localparam logic [15:0] OP_REPLY    = 16'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MATCH,
    S_READ,
    S_EXEC,
    S_SCAN_RD,
    S_SCAN_EX,
    S_FLUSH
  } state_t;

  typedef struct packed {
    action_t     action;
    logic [15:0] handle;
    logic [47:0] mac;
    logic [31:0] qip;
    logic [31:0] aip;
    logic [3:0]  port;
  } result_t;

  typedef struct packed {
    logic capture;   // take the input word
    logic match;     // register key match and free search
    logic rd_hit;    // read slot memories at the hit slot
    logic rd_scan;   // read slot memories at the scan slot
    logic exec;      // apply send/frame action
    logic scan_clr;  // restart the scan
    logic scan_ex;   // apply aging to the scan slot, advance
    logic flush;     // release the held tick result
  } cmd_t;

  typedef struct packed {
    logic       out_free;
    logic       scan_emit;
    logic       held_valid;
    logic       scan_last;
  } sts_t;

endpackage

>>> src/arpc_ctrl.sv
// ----------------------------------------------------------------------------
// arpc_ctrl: sequencing state machine
// Steps a word through match, read and execute, or walks all slots on a tick.
// ----------------------------------------------------------------------------
module arpc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_req_type,
  output logic              in_stall,
  input  arpc_pkg::sts_t    sts,
  output arpc_pkg::cmd_t    cmd
);

  arpc_pkg::state_t state_r, state_nxt;
  logic scan_go;
  logic flush_go;

  assign scan_go  = !(sts.scan_emit && sts.held_valid && !sts.out_free);
  assign flush_go = !sts.held_valid || sts.out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= arpc_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      arpc_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_req_type == arpc_pkg::REQ_TICK) ? arpc_pkg::S_SCAN_RD
                                                           : arpc_pkg::S_MATCH;
        end
      end
      arpc_pkg::S_MATCH:   state_nxt = arpc_pkg::S_READ;
      arpc_pkg::S_READ:    state_nxt = arpc_pkg::S_EXEC;
      arpc_pkg::S_EXEC: begin
        if (sts.out_free) state_nxt = arpc_pkg::S_IDLE;
      end
      arpc_pkg::S_SCAN_RD: state_nxt = arpc_pkg::S_SCAN_EX;
      arpc_pkg::S_SCAN_EX: begin
        if (scan_go) begin
          state_nxt = sts.scan_last ? arpc_pkg::S_FLUSH : arpc_pkg::S_SCAN_RD;
        end
      end
      arpc_pkg::S_FLUSH: begin
        if (flush_go) state_nxt = arpc_pkg::S_IDLE;
      end
      default: state_nxt = arpc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      arpc_pkg::S_IDLE: begin
        in_stall     = 1'b0;
        cmd.capture  = in_valid;
        cmd.scan_clr = in_valid && (in_req_type == arpc_pkg::REQ_TICK);
      end
      arpc_pkg::S_MATCH:   cmd.match   = 1'b1;
      arpc_pkg::S_READ:    cmd.rd_hit  = 1'b1;
      arpc_pkg::S_EXEC:    cmd.exec    = sts.out_free;
      arpc_pkg::S_SCAN_RD: cmd.rd_scan = 1'b1;
      arpc_pkg::S_SCAN_EX: cmd.scan_ex = scan_go;
      arpc_pkg::S_FLUSH:   cmd.flush   = flush_go;
      default: cmd = '0;
    endcase
  end

`ifndef SYNTHESIS
  a_held_in_tick: assert property (@(posedge clk) disable iff (!rst_n)
    sts.held_valid |-> (state_r == arpc_pkg::S_SCAN_RD || state_r == arpc_pkg::S_SCAN_EX ||
                        state_r == arpc_pkg::S_FLUSH))
    else $error("held tick result outside a scan");
  a_tick_to_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_clr |=> state_r == arpc_pkg::S_SCAN_RD)
    else $error("tick did not start a scan");
  a_idle_after_flush: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.flush |=> state_r == arpc_pkg::S_IDLE)
    else $error("flush did not end the tick");
`endif

endmodule

>>> src/arpc_dp.sv
// ----------------------------------------------------------------------------
// arpc_dp: slot table, configuration and result datapath
// Holds the slot table, matches keys in parallel, ages slots, and owns the
// output register plus a one-word hold so the final tick result gets last.
// ----------------------------------------------------------------------------
module arpc_dp #(
  parameter int ENTRIES = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  arpc_pkg::cmd_t    cmd,
  output arpc_pkg::sts_t    sts,
  input  logic              cfg_valid,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  input  logic [1:0]        in_req_type,
  input  logic [31:0]       in_next_hop_ip,
  input  logic [15:0]       in_packet_handle,
  input  logic [13:0]       in_frame_len,
  input  logic [47:0]       in_arp_fixed_header,
  input  logic [15:0]       in_arp_opcode,
  input  logic [47:0]       in_sender_mac,
  input  logic [31:0]       in_sender_ip,
  input  logic [31:0]       in_target_ip,
  input  logic [3:0]        in_port,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_action,
  output logic [15:0]       out_handle,
  output logic [47:0]       out_dest_mac,
  output logic [31:0]       out_query_ip,
  output logic [31:0]       out_answer_ip,
  output logic [3:0]        out_port,
  output logic              out_last
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // configuration
  logic [31:0] local_ip_r;
  logic [15:0] pend_lim_r;
  logic [15:0] refr_lim_r;

  // captured word
  logic [1:0]  type_r;
  logic [31:0] hop_r;
  logic [15:0] handle_r;
  logic [13:0] flen_r;
  logic [47:0] hdr_r;
  logic [15:0] op_r;
  logic [47:0] smac_r;
  logic [31:0] sip_r;
  logic [31:0] tip_r;
  logic [3:0]  port_r;
  logic [31:0] now_r;

  // slot table
  arpc_pkg::slot_st_t slot_st_r [ENTRIES];
  logic               has_r     [ENTRIES];
  logic [31:0]        key_r     [ENTRIES];
  logic [31:0]        ip_mem    [ENTRIES];
  logic [47:0]        mac_mem   [ENTRIES];
  logic [31:0]        stamp_mem [ENTRIES];
  logic [15:0]        hnd_mem   [ENTRIES];
  logic [31:0] ip_q;
  logic [47:0] mac_q;
  logic [31:0] stamp_q;
  logic [15:0] hnd_q;

  // match results
  logic          hit_r, free_r;
  logic [IW-1:0] hit_idx_r, free_idx_r;
  logic          hit_c, free_c;
  logic [IW-1:0] hit_idx_c, free_idx_c;
  logic [31:0]   key_c;

  logic [IW-1:0] scan_idx_r;
  logic [IW-1:0] rd_addr;

  // output and hold
  logic              out_valid_r;
  arpc_pkg::result_t out_r;
  logic              out_last_r;
  logic              held_valid_r;
  arpc_pkg::result_t held_r;
  logic              out_free;

  // execute and scan decode
  logic              is_send, frame_ok, miss_alloc, resolve;
  logic              ex_emit;
  arpc_pkg::result_t ex_res;
  arpc_pkg::slot_st_t sc_st;
  logic              sc_has;
  logic [31:0]       age;
  logic              sc_expire, sc_refresh, sc_emit;
  arpc_pkg::result_t sc_res;
  logic              push;
  arpc_pkg::result_t push_res;
  logic              push_last;
  logic              stamp_we;
  logic [IW-1:0]     stamp_wa;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_ip_r <= arpc_pkg::LOCAL_IP_RST;
      pend_lim_r <= arpc_pkg::PENDING_LIMIT_RST;
      refr_lim_r <= arpc_pkg::REFRESH_LIMIT_RST;
    end else if (cfg_valid) begin
      if (cfg_index == arpc_pkg::CFG_LOCAL_IP)      local_ip_r <= cfg_data;
      if (cfg_index == arpc_pkg::CFG_PENDING_LIMIT) pend_lim_r <= cfg_data[15:0];
      if (cfg_index == arpc_pkg::CFG_REFRESH_LIMIT) refr_lim_r <= cfg_data[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      type_r   <= in_req_type;
      hop_r    <= in_next_hop_ip;
      handle_r <= in_packet_handle;
      flen_r   <= in_frame_len;
      hdr_r    <= in_arp_fixed_header;
      op_r     <= in_arp_opcode;
      smac_r   <= in_sender_mac;
      sip_r    <= in_sender_ip;
      tip_r    <= in_target_ip;
      port_r   <= in_port;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r <= '0;
    end else if (cmd.capture && in_req_type == arpc_pkg::REQ_TICK) begin
      now_r <= now_r + 32'd1;
    end
  end

  // parallel key match and lowest free slot
  assign key_c = (type_r == arpc_pkg::REQ_SEND) ? hop_r : sip_r;

  always_comb begin
    hit_c      = 1'b0;
    free_c     = 1'b0;
    hit_idx_c  = '0;
    free_idx_c = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (slot_st_r[i] != arpc_pkg::SLOT_UNUSED && key_r[i] == key_c) begin
        hit_c     = 1'b1;
        hit_idx_c = IW'(i);
      end
      if (slot_st_r[i] == arpc_pkg::SLOT_UNUSED) begin
        free_c     = 1'b1;
        free_idx_c = IW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.match) begin
      hit_r      <= hit_c;
      free_r     <= free_c;
      hit_idx_r  <= hit_idx_c;
      free_idx_r <= free_idx_c;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_clr) begin
      scan_idx_r <= '0;
    end else if (cmd.scan_ex) begin
      scan_idx_r <= scan_idx_r + IW'(1);
    end
  end

  assign rd_addr = cmd.rd_scan ? scan_idx_r : hit_idx_r;

  // execute decode for send and frame words
  assign is_send    = (type_r == arpc_pkg::REQ_SEND);
  assign frame_ok   = (type_r == arpc_pkg::REQ_FRAME) && (flen_r >= arpc_pkg::MIN_FRAME) &&
                      (hdr_r == arpc_pkg::GOOD_HEADER);
  assign miss_alloc = cmd.exec && is_send && !hit_r && free_r;
  assign resolve    = cmd.exec && frame_ok && (op_r == arpc_pkg::OP_REPLY) && hit_r;

  always_comb begin
    ex_emit = 1'b0;
    ex_res  = '0;
    if (is_send) begin
      ex_emit       = 1'b1;
      ex_res.handle = handle_r;
      if (hit_r) begin
        if (slot_st_r[hit_idx_r] == arpc_pkg::SLOT_PEND_NOMAC) begin
          ex_res.action = arpc_pkg::ACT_DROP;
        end else begin
          ex_res.action = arpc_pkg::ACT_FWD;
          ex_res.mac    = mac_q;
        end
      end else if (free_r) begin
        ex_res.action = arpc_pkg::ACT_REQ;
        ex_res.handle = '0;
        ex_res.qip    = hop_r;
      end else begin
        ex_res.action = arpc_pkg::ACT_DROP;
      end
    end else if (frame_ok && op_r == arpc_pkg::OP_REQUEST) begin
      if (tip_r == local_ip_r) begin
        ex_emit       = 1'b1;
        ex_res.action = arpc_pkg::ACT_REPLY;
        ex_res.mac    = smac_r;
        ex_res.qip    = sip_r;
        ex_res.aip    = tip_r;
        ex_res.port   = port_r;
      end
    end else if (frame_ok && op_r == arpc_pkg::OP_REPLY) begin
      if (hit_r && has_r[hit_idx_r]) begin
        ex_emit       = 1'b1;
        ex_res.action = arpc_pkg::ACT_FWD;
        ex_res.handle = hnd_q;
        ex_res.mac    = smac_r;
      end
    end
  end

  // aging decode for the scan slot
  assign sc_st      = slot_st_r[scan_idx_r];
  assign sc_has     = has_r[scan_idx_r];
  assign age        = now_r - stamp_q;
  assign sc_expire  = (sc_st == arpc_pkg::SLOT_PEND_NOMAC || sc_st == arpc_pkg::SLOT_PEND_MAC) &&
                      (age > {16'd0, pend_lim_r});
  assign sc_refresh = (sc_st == arpc_pkg::SLOT_RESOLVED) && (age > {16'd0, refr_lim_r});
  assign sc_emit    = (sc_expire && sc_has) || sc_refresh;

  always_comb begin
    sc_res = '0;
    if (sc_refresh) begin
      sc_res.action = arpc_pkg::ACT_REQ;
      sc_res.qip    = ip_q;
    end else begin
      sc_res.action = arpc_pkg::ACT_DROP;
      sc_res.handle = hnd_q;
    end
  end

  // slot state and packet flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) begin
        slot_st_r[i] <= arpc_pkg::SLOT_UNUSED;
        has_r[i]     <= 1'b0;
      end
    end else begin
      if (miss_alloc) begin
        slot_st_r[free_idx_r] <= arpc_pkg::SLOT_PEND_NOMAC;
        has_r[free_idx_r]     <= 1'b1;
      end
      if (resolve) begin
        slot_st_r[hit_idx_r] <= arpc_pkg::SLOT_RESOLVED;
        has_r[hit_idx_r]     <= 1'b0;
      end
      if (cmd.scan_ex && sc_expire) begin
        slot_st_r[scan_idx_r] <= arpc_pkg::SLOT_UNUSED;
        has_r[scan_idx_r]     <= 1'b0;
      end
      if (cmd.scan_ex && sc_refresh) begin
        slot_st_r[scan_idx_r] <= arpc_pkg::SLOT_PEND_MAC;
      end
    end
  end

  // match keys, one register per slot
  always_ff @(posedge clk) begin
    if (miss_alloc) key_r[free_idx_r] <= hop_r;
  end

  assign stamp_we = miss_alloc || resolve || (cmd.scan_ex && sc_refresh);
  assign stamp_wa = miss_alloc ? free_idx_r : (resolve ? hit_idx_r : scan_idx_r);

  always_ff @(posedge clk) begin
    if (miss_alloc) begin
      ip_mem[free_idx_r]  <= hop_r;
      hnd_mem[free_idx_r] <= handle_r;
    end
    if (resolve) mac_mem[hit_idx_r] <= smac_r;
    if (stamp_we) stamp_mem[stamp_wa] <= now_r;
    if (cmd.rd_hit || cmd.rd_scan) begin
      ip_q    <= ip_mem[rd_addr];
      mac_q   <= mac_mem[rd_addr];
      stamp_q <= stamp_mem[rd_addr];
      hnd_q   <= hnd_mem[rd_addr];
    end
  end

  // output register and hold stage
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    push      = 1'b0;
    push_res  = held_r;
    push_last = 1'b0;
    if (cmd.exec) begin
      push      = ex_emit;
      push_res  = ex_res;
      push_last = 1'b1;
    end else if (cmd.scan_ex) begin
      push = sc_emit && held_valid_r;
    end else if (cmd.flush) begin
      push      = held_valid_r;
      push_last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      held_valid_r <= 1'b0;
    end else begin
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.scan_ex && sc_emit) begin
        held_valid_r <= 1'b1;
      end else if (cmd.flush) begin
        held_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_r      <= push_res;
      out_last_r <= push_last;
    end
    if (cmd.scan_ex && sc_emit) held_r <= sc_res;
  end

  assign out_valid     = out_valid_r;
  assign out_action    = out_r.action;
  assign out_handle    = out_r.handle;
  assign out_dest_mac  = out_r.mac;
  assign out_query_ip  = out_r.qip;
  assign out_answer_ip = out_r.aip;
  assign out_port      = out_r.port;
  assign out_last      = out_last_r;

  assign sts.out_free   = out_free;
  assign sts.scan_emit  = sc_emit;
  assign sts.held_valid = held_valid_r;
  assign sts.scan_last  = (scan_idx_r == IW'(ENTRIES - 1));

`ifndef SYNTHESIS
  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> out_free)
    else $error("result pushed over a waiting word");
  a_no_double_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    miss_alloc |-> slot_st_r[free_idx_r] == arpc_pkg::SLOT_UNUSED)
    else $error("allocated a slot in use");
  a_resolve_hit: assert property (@(posedge clk) disable iff (!rst_n)
    resolve |-> slot_st_r[hit_idx_r] != arpc_pkg::SLOT_UNUSED)
    else $error("resolved an unused slot");
`endif

endmodule

>>> src/arp_cache_resolver_top.sv
// Steps: a send or frame word passes key match, slot memory read and execute
//   before it reaches the output register; execute waits on a held output.
// Words: a new word is taken only after the last one is done; a tick walks
//   every slot in order (memory read, then aging), then flushes the held result.
// Reset: synchronous active-low rst_n frees all slots, clears the seconds
//   count and loads the register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
// arp_cache_resolver_top: ARP cache resolver
// Maps next-hop IPv4 addresses to MACs, issues ARP requests and replies, and
// ages the table once per tick word.
// ----------------------------------------------------------------------------
module arp_cache_resolver_top #(
  parameter int ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write channel, always ready
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // input word channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [31:0] in_next_hop_ip,
  input  logic [15:0] in_packet_handle,
  input  logic [13:0] in_frame_len,
  input  logic [47:0] in_arp_fixed_header,
  input  logic [15:0] in_arp_opcode,
  input  logic [47:0] in_sender_mac,
  input  logic [31:0] in_sender_ip,
  input  logic [31:0] in_target_ip,
  input  logic [3:0]  in_port,
  // result word channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_action,
  output logic [15:0] out_handle,
  output logic [47:0] out_dest_mac,
  output logic [31:0] out_query_ip,
  output logic [31:0] out_answer_ip,
  output logic [3:0]  out_port,
  output logic        out_last
);

  arpc_pkg::cmd_t cmd;
  arpc_pkg::sts_t sts;

  // registers take a write in any cycle; software writes only while idle
  assign cfg_ready = 1'b1;

  // sequencer: accepts a word only when idle, then steps it through the
  // datapath; a tick walks every slot in order
  arpc_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_stall    (in_stall),
    .sts         (sts),
    .cmd         (cmd)
  );

  // slot table, match, aging and the output register
  arpc_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .cfg_valid           (cfg_valid),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_req_type         (in_req_type),
    .in_next_hop_ip      (in_next_hop_ip),
    .in_packet_handle    (in_packet_handle),
    .in_frame_len        (in_frame_len),
    .in_arp_fixed_header (in_arp_fixed_header),
    .in_arp_opcode       (in_arp_opcode),
    .in_sender_mac       (in_sender_mac),
    .in_sender_ip        (in_sender_ip),
    .in_target_ip        (in_target_ip),
    .in_port             (in_port),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_action          (out_action),
    .out_handle          (out_handle),
    .out_dest_mac        (out_dest_mac),
    .out_query_ip        (out_query_ip),
    .out_answer_ip       (out_answer_ip),
    .out_port            (out_port),
    .out_last            (out_last)
  );

endmodule
